[rtl/core/fhd_pkg.sv]
package fhd_pkg;

    // Header layout, byte offsets into the 20-byte little-endian header
    localparam int HDR_BYTES    = 20;
    localparam int HDR_CNT_W    = $clog2(HDR_BYTES);
    localparam int OFS_VERSION  = 4;
    localparam int OFS_KIND     = 6;
    localparam int OFS_FLAGS    = 8;
    localparam int OFS_LENGTH   = 12;
    localparam int OFS_RESERVED = 16;
    localparam int MAGIC_BYTES  = 4;

    // "TRVR", first byte in the low bits
    localparam logic [31:0] MAGIC_WORD = 32'h5256_5254;

    localparam int DATA_W  = 8;
    localparam int KIND_W  = 16;
    localparam int VER_W   = 16;
    localparam int LEN_W   = 32;
    localparam int ERR_W   = 3;
    localparam int TYPE_W  = 2;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int M_TDATA_W = 64;

    typedef enum logic [TYPE_W-1:0] {
        RT_HEADER  = 2'd0,
        RT_PAYLOAD = 2'd1,
        RT_ERROR   = 2'd2
    } rtype_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_MAGIC    = 3'd0,
        ERR_VERSION  = 3'd1,
        ERR_KIND     = 3'd2,
        ERR_RESERVED = 3'd3,
        ERR_LENGTH   = 3'd4
    } err_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_VERSION = 2'd0,
        CFG_KIND_MIN    = 2'd1,
        CFG_KIND_MAX    = 2'd2,
        CFG_MAX_PAYLOAD = 2'd3
    } cfg_index_t;

    typedef enum logic {
        PH_HEADER  = 1'b0,
        PH_PAYLOAD = 1'b1
    } phase_t;

endpackage

[rtl/core/frame_header_deframer_core.sv]
// Frame header deframer. Takes one received byte per transaction on s_, collects
// the 20-byte header (magic "TRVR", version, kind, flags, length, reserved, all
// little-endian), checks it at the last header byte and returns one header or
// error transaction on m_; accepted payload bytes then pass through one per
// transaction, the final one with m_tlast. The first 19 header bytes return nothing.
// One byte is taken every cycle while s_tready is high; a result appears on m_
// the cycle after its byte is taken, held in a single output register, and
// s_tready drops only while that register holds a result that m_tready does not
// take. No clearing pass after reset. The configuration registers must be written
// only while the stream is idle; the block itself does not enforce this.
module frame_header_deframer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fhd_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fhd_pkg::DATA_W-1:0]      s_tdata,   // [7:0] in_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] frame_kind, [47:16] frame_length, [55:48] data_byte,
    // [58:56] error_code, [63:59] zero
    output logic [fhd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fhd_pkg::TYPE_W-1:0]      m_tuser,   // [1:0] result_type
    output logic                            m_tlast
);
    import fhd_pkg::*;

    localparam logic [HDR_CNT_W-1:0] CNT_LAST = HDR_CNT_W'(HDR_BYTES - 1);

    // configuration
    logic [VER_W-1:0]  exp_version_reg;
    logic [KIND_W-1:0] kind_min_reg;
    logic [KIND_W-1:0] kind_max_reg;
    logic [LEN_W-1:0]  max_payload_reg;

    // control state
    phase_t                 phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // header fields as they arrive
    logic                   magic_ok_reg, magic_ok_next;
    logic                   zero_ok_reg, zero_ok_next;
    logic [VER_W-1:0]       version_reg, version_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [LEN_W-1:0]       length_reg, length_next;

    // result register
    rtype_t                 out_type_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic                   out_last_reg;
    err_code_t              out_err_reg;

    // result of the current transaction
    logic                   res_valid;
    rtype_t                 res_type;
    logic [KIND_W-1:0]      res_kind;
    logic [LEN_W-1:0]       res_len;
    logic [DATA_W-1:0]      res_data;
    logic                   res_last;
    err_code_t              res_err;

    logic                   in_fire;
    logic                   byte_zero;
    logic                   magic_match;
    logic                   zero_final;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign byte_zero   = (s_tdata == '0);
    assign magic_match = (s_tdata == MAGIC_WORD[{cnt_reg[1:0], 3'b000} +: DATA_W]);
    assign zero_final  = zero_ok_reg && byte_zero;

    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        magic_ok_next = magic_ok_reg;
        zero_ok_next  = zero_ok_reg;
        version_next  = version_reg;
        kind_next     = kind_reg;
        length_next   = length_reg;

        res_valid = 1'b0;
        res_type  = RT_HEADER;
        res_kind  = '0;
        res_len   = '0;
        res_data  = '0;
        res_last  = 1'b0;
        res_err   = ERR_MAGIC;

        if (in_fire) begin
            if (phase_reg == PH_PAYLOAD) begin
                res_valid = 1'b1;
                res_type  = RT_PAYLOAD;
                res_data  = s_tdata;
                rem_next  = rem_reg - LEN_W'(1);
                if (rem_reg <= LEN_W'(1)) begin
                    res_last   = 1'b1;
                    phase_next = PH_HEADER;
                    cnt_next   = '0;
                    rem_next   = '0;
                end
            end else begin
                // fold each byte into its field
                if (cnt_reg == '0) begin
                    magic_ok_next = magic_match;
                    zero_ok_next  = 1'b1;
                end else if (cnt_reg < HDR_CNT_W'(MAGIC_BYTES)) begin
                    magic_ok_next = magic_ok_reg && magic_match;
                end
                if (cnt_reg == HDR_CNT_W'(OFS_VERSION)) begin
                    version_next[7:0] = s_tdata;
                end
                if (cnt_reg == HDR_CNT_W'(OFS_VERSION + 1)) begin
                    version_next[15:8] = s_tdata;
                end
                if (cnt_reg == HDR_CNT_W'(OFS_KIND)) begin
                    kind_next[7:0] = s_tdata;
                end
                if (cnt_reg == HDR_CNT_W'(OFS_KIND + 1)) begin
                    kind_next[15:8] = s_tdata;
                end
                if ((cnt_reg >= HDR_CNT_W'(OFS_FLAGS) && cnt_reg < HDR_CNT_W'(OFS_LENGTH))
                        || cnt_reg >= HDR_CNT_W'(OFS_RESERVED)) begin
                    zero_ok_next = zero_ok_reg && byte_zero;
                end
                if (cnt_reg >= HDR_CNT_W'(OFS_LENGTH) && cnt_reg < HDR_CNT_W'(OFS_RESERVED)) begin
                    length_next[{cnt_reg[1:0], 3'b000} +: DATA_W] = s_tdata;
                end

                if (cnt_reg == CNT_LAST) begin
                    cnt_next  = '0;
                    res_valid = 1'b1;
                    res_last  = 1'b1;
                    res_type  = RT_ERROR;
                    if (!magic_ok_reg) begin
                        res_err = ERR_MAGIC;
                    end else if (version_reg != exp_version_reg) begin
                        res_err = ERR_VERSION;
                    end else if (kind_reg < kind_min_reg || kind_reg > kind_max_reg) begin
                        res_err = ERR_KIND;
                    end else if (!zero_final) begin
                        res_err = ERR_RESERVED;
                    end else if (length_reg > max_payload_reg) begin
                        res_err = ERR_LENGTH;
                    end else begin
                        res_type = RT_HEADER;
                        res_kind = kind_reg;
                        res_len  = length_reg;
                        if (length_reg != '0) begin
                            res_last   = 1'b0;
                            phase_next = PH_PAYLOAD;
                            rem_next   = length_reg;
                        end
                    end
                end else begin
                    cnt_next = cnt_reg + HDR_CNT_W'(1);
                end
            end
        end

        m_tvalid_next = res_valid || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg <= VER_W'(1);
            kind_min_reg    <= '0;
            kind_max_reg    <= '1;
            max_payload_reg <= '1;
            phase_reg       <= PH_HEADER;
            cnt_reg         <= '0;
            rem_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_EXP_VERSION: exp_version_reg <= cfg_wdata[VER_W-1:0];
                    CFG_KIND_MIN:    kind_min_reg    <= cfg_wdata[KIND_W-1:0];
                    CFG_KIND_MAX:    kind_max_reg    <= cfg_wdata[KIND_W-1:0];
                    CFG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        magic_ok_reg <= magic_ok_next;
        zero_ok_reg  <= zero_ok_next;
        version_reg  <= version_next;
        kind_reg     <= kind_next;
        length_reg   <= length_next;
        if (res_valid) begin
            out_type_reg <= res_type;
            out_kind_reg <= res_kind;
            out_len_reg  <= res_len;
            out_data_reg <= res_data;
            out_last_reg <= res_last;
            out_err_reg  <= res_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_type_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - KIND_W - LEN_W - DATA_W - ERR_W){1'b0}},
                       out_err_reg, out_data_reg, out_len_reg, out_kind_reg};

endmodule

[rtl/core/fhd_checker.sv]
module fhd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fhd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [fhd_pkg::TYPE_W-1:0]      m_tuser,
    input  logic                            m_tlast
);
    import fhd_pkg::*;

    // a stalled result keeps its content
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an error always closes the frame
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RT_ERROR |-> m_tlast && m_tdata[55:0] == 56'd0)
        else $error("error result malformed");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RT_PAYLOAD |-> m_tdata[47:0] == 48'd0
                                              && m_tdata[58:56] == 3'd0)
        else $error("payload transaction carries header fields");

    // a header is last exactly when its frame has no payload
    a_hdr_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RT_HEADER |-> m_tlast == (m_tdata[47:16] == 32'd0))
        else $error("header last flag disagrees with length");

endmodule

bind frame_header_deframer_core fhd_checker u_fhd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
